// ===== rtl/kmm_pkg.sv =====
// kmm_pkg: shared widths, codes and result layout for the k-mismatch matcher.
// No dependencies; imported by every module of the block.
`default_nettype none

package kmm_pkg;

  localparam int CFG_W     = 7;   // width of both configuration registers
  localparam int SYM_W     = 8;
  localparam int PIDX_W    = 6;
  localparam int START_W   = 20;
  localparam int TALLY_W   = 7;
  localparam int GROUP     = 8;   // tallies per first-level select group
  localparam int GROUP_LOG = 3;

  localparam logic [TALLY_W-1:0] TALLY_MAX = '1;

  localparam int PATTERN_MAX_DEF = 64;
  localparam int TEXT_MAX_DEF    = 1048576;

  // beat kinds carried on tuser
  localparam logic REQ_LOAD = 1'b0;
  localparam logic REQ_TEXT = 1'b1;

  // configuration register indexes
  localparam logic CFG_PATTERN_LENGTH = 1'b0;
  localparam logic CFG_MAX_MISMATCHES = 1'b1;

  // result beat, alignment_start in the lowest bits
  typedef struct packed {
    logic               found;
    logic [TALLY_W-1:0] mismatch_count;
    logic [START_W-1:0] alignment_start;
  } kmm_res_t;

endpackage

`default_nettype wire

// ===== rtl/kmm_cell.sv =====
// kmm_cell: one alignment cell, holding a pattern byte and the running
// mismatch tally of the prefix that ends on it. Depends on kmm_pkg.
`default_nettype none

module kmm_cell (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        shift_en,
  input  wire logic [kmm_pkg::SYM_W-1:0]   sym,
  input  wire logic                        pat_we,
  input  wire logic [kmm_pkg::SYM_W-1:0]   pat_din,
  input  wire logic [kmm_pkg::TALLY_W-1:0] tally_in,
  output logic      [kmm_pkg::TALLY_W-1:0] tally_out
);
  import kmm_pkg::*;

  logic [SYM_W-1:0]   pat_r;
  logic [TALLY_W-1:0] tally_r;
  logic [TALLY_W-1:0] tally_nxt;

  always_comb begin
    tally_nxt = tally_in;
    if (sym != pat_r && tally_in != TALLY_MAX) begin
      tally_nxt = tally_in + TALLY_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (pat_we) begin
      pat_r <= pat_din;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tally_r <= '0;
    end else if (shift_en) begin
      tally_r <= tally_nxt;
    end
  end

  assign tally_out = tally_r;

endmodule

`default_nettype wire

// ===== rtl/kmm_sel.sv =====
// kmm_sel: two-level registered select of the tally for the active length,
// limit compare and output register. Depends on kmm_pkg.
`default_nettype none

module kmm_sel #(
  parameter int PATTERN_MAX = kmm_pkg::PATTERN_MAX_DEF,
  parameter int LEN_W       = kmm_pkg::CFG_W
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic [kmm_pkg::TALLY_W-1:0] tally [PATTERN_MAX],
  input  wire logic                        a_valid,
  input  wire logic [kmm_pkg::START_W-1:0] a_start,
  input  wire logic [LEN_W-1:0]            a_sel,
  input  wire logic [kmm_pkg::CFG_W-1:0]   max_mis,
  output logic                             b_ready,
  output logic                             out_valid,
  input  wire logic                        out_ready,
  output kmm_pkg::kmm_res_t                out_res
);
  import kmm_pkg::*;

  localparam int N_GRP = (PATTERN_MAX + GROUP - 1) / GROUP;
  localparam int HI_W  = (N_GRP > 1) ? $clog2(N_GRP) : 1;

  logic [TALLY_W-1:0] tally_pad [N_GRP*GROUP];
  logic [TALLY_W-1:0] grp_nxt   [N_GRP];
  logic [TALLY_W-1:0] b_grp_r   [N_GRP];
  logic               b_valid_r;
  logic [START_W-1:0] b_start_r;
  logic [HI_W-1:0]    b_hi_r;
  logic [LEN_W-1:0]   sel_hi;
  logic [GROUP_LOG-1:0] sel_lo;
  logic               out_valid_r;
  kmm_res_t           res_r;
  kmm_res_t           res_nxt;
  logic               out_move;

  genvar gi;
  generate
    for (gi = 0; gi < N_GRP*GROUP; gi++) begin : g_pad
      if (gi < PATTERN_MAX) begin : g_used
        assign tally_pad[gi] = tally[gi];
      end else begin : g_fill
        assign tally_pad[gi] = '0;
      end
    end
  endgenerate

  assign sel_lo = a_sel[GROUP_LOG-1:0];
  assign sel_hi = a_sel >> GROUP_LOG;

  always_comb begin
    for (int g = 0; g < N_GRP; g++) begin
      grp_nxt[g] = tally_pad[g*GROUP + int'(sel_lo)];
    end
  end

  assign out_move = !out_valid_r || out_ready;
  assign b_ready  = !b_valid_r || out_move;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_valid_r <= 1'b0;
    end else if (b_ready) begin
      b_valid_r <= a_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (b_ready) begin
      for (int g = 0; g < N_GRP; g++) begin
        b_grp_r[g] <= grp_nxt[g];
      end
      b_start_r <= a_start;
      b_hi_r    <= sel_hi[HI_W-1:0];
    end
  end

  always_comb begin
    res_nxt.alignment_start = b_start_r;
    res_nxt.mismatch_count  = b_grp_r[b_hi_r];
    res_nxt.found           = (b_grp_r[b_hi_r] <= max_mis);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_move) begin
      out_valid_r <= b_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (out_move) begin
      res_r <= res_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_res   = res_r;

endmodule

`default_nettype wire

// ===== rtl/k_mismatch_matcher_unit.sv =====
// k_mismatch_matcher_unit: approximate pattern matcher, top level.
// Depends on kmm_pkg, kmm_cell and kmm_sel.
//
// Usage:
//   Input beats on in_*: tuser low loads symbol into pattern slot
//   pattern_index; tuser high streams one text byte, tlast marking the last
//   byte of a text. Indexes at or beyond PATTERN_MAX are dropped.
//   Each text byte that completes a window of pattern_length bytes yields one
//   result beat on out_*: window start, Hamming mismatch count, found flag.
//   Registers must be written on cfg_* only while the block is idle (a user rule; the block has no check for it).
//   Throughput: one beat per cycle while in_tready is high; every cell updates its
//   tally in the same cycle, so the chain of cells takes a text byte each clock.
//   Each result passes cell update, group select and output register in turn.
//   Stalls: three result slots (cell stage, select stage, output register)
//   absorb back-pressure; in_tready drops only once all three hold results.
//   Load beats and text beats that close no window take no result slot.
//   Reset (rst_n low, synchronous): tallies and text position cleared,
//   pattern_length = 1, max_mismatches = 0. Pattern bytes are not cleared.
`default_nettype none

module k_mismatch_matcher_unit #(
  parameter int PATTERN_MAX = kmm_pkg::PATTERN_MAX_DEF,
  parameter int TEXT_MAX    = kmm_pkg::TEXT_MAX_DEF
) (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  // in_tdata: symbol[7:0], pattern_index[13:8], zero[15:14]
  input  wire logic                      in_tvalid,
  output logic                           in_tready,
  input  wire logic [15:0]               in_tdata,
  // in_tuser: req_type[0]
  input  wire logic                      in_tuser,
  input  wire logic                      in_tlast,
  // out_tdata: alignment_start[19:0], mismatch_count[26:20], found[27], zero[31:28]
  output logic                           out_tvalid,
  input  wire logic                      out_tready,
  output logic [31:0]                    out_tdata,
  input  wire logic                      cfg_we,
  input  wire logic                      cfg_index,
  input  wire logic [kmm_pkg::CFG_W-1:0] cfg_wdata
);
  import kmm_pkg::*;

  localparam int LEN_W  = ($clog2(PATTERN_MAX + 1) > CFG_W) ? $clog2(PATTERN_MAX + 1) : CFG_W;
  localparam int POS_W  = $clog2(TEXT_MAX);
  localparam int CALC_A = (POS_W + 1 > LEN_W) ? POS_W + 1 : LEN_W;
  localparam int CALC_W = (CALC_A > START_W) ? CALC_A : START_W;

  logic [CFG_W-1:0]   cfg_len_r;
  logic [CFG_W-1:0]   cfg_max_r;
  logic [POS_W-1:0]   pos_r;
  logic [POS_W-1:0]   pos_nxt;
  logic               clr_r;
  logic               a_valid_r;
  logic [START_W-1:0] a_start_r;
  logic [LEN_W-1:0]   a_sel_r;

  logic [SYM_W-1:0]   sym;
  logic [PIDX_W-1:0]  pidx;
  logic               in_acc;
  logic               text_acc;
  logic               load_acc;
  logic               a_move;
  logic               b_ready;
  logic [LEN_W-1:0]   len;
  logic [CALC_W-1:0]  pos_inc;
  logic [CALC_W-1:0]  start_w;
  logic               has_res;
  logic               out_valid;
  kmm_res_t           out_res;

  logic [TALLY_W-1:0] tally    [PATTERN_MAX];
  logic [TALLY_W-1:0] chain_in [PATTERN_MAX];

  assign sym  = in_tdata[SYM_W-1:0];
  assign pidx = in_tdata[SYM_W +: PIDX_W];

  assign a_move    = !a_valid_r || b_ready;
  assign in_tready = a_move;
  assign in_acc    = in_tvalid && a_move;
  assign text_acc  = in_acc && (in_tuser == REQ_TEXT);
  assign load_acc  = in_acc && (in_tuser == REQ_LOAD);

  // configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_len_r <= CFG_W'(1);
      cfg_max_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_PATTERN_LENGTH: cfg_len_r <= cfg_wdata;
        CFG_MAX_MISMATCHES: cfg_max_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // active length clamped to 1..PATTERN_MAX
  always_comb begin
    if (cfg_len_r == '0) begin
      len = LEN_W'(1);
    end else if (LEN_W'(cfg_len_r) > LEN_W'(PATTERN_MAX)) begin
      len = LEN_W'(PATTERN_MAX);
    end else begin
      len = LEN_W'(cfg_len_r);
    end
  end

  assign pos_inc = CALC_W'(pos_r) + CALC_W'(1);
  assign has_res = (pos_inc >= CALC_W'(len));
  assign start_w = pos_inc - CALC_W'(len);

  always_comb begin
    pos_nxt = pos_r;
    if (in_tlast) begin
      pos_nxt = '0;
    end else if (pos_r != POS_W'(TEXT_MAX - 1)) begin
      pos_nxt = pos_r + POS_W'(1);
    end
  end

  // clr_r: previous text ended, so the next byte starts from empty tallies
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r     <= '0;
      clr_r     <= 1'b0;
      a_valid_r <= 1'b0;
    end else begin
      if (text_acc) begin
        pos_r <= pos_nxt;
        clr_r <= in_tlast;
      end
      if (a_move) begin
        a_valid_r <= text_acc && has_res;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (a_move) begin
      a_start_r <= start_w[START_W-1:0];
      a_sel_r   <= len - LEN_W'(1);
    end
  end

  genvar k;
  generate
    for (k = 0; k < PATTERN_MAX; k++) begin : g_cell
      logic pat_we;

      if (k == 0) begin : g_head
        assign chain_in[k] = '0;
      end else begin : g_link
        assign chain_in[k] = clr_r ? '0 : tally[k-1];
      end

      if (k < (1 << PIDX_W)) begin : g_wr
        assign pat_we = load_acc && (pidx == PIDX_W'(k));
      end else begin : g_nowr
        assign pat_we = 1'b0;
      end

      kmm_cell u_cell (
        .clk       (clk),
        .rst_n     (rst_n),
        .shift_en  (text_acc),
        .sym       (sym),
        .pat_we    (pat_we),
        .pat_din   (sym),
        .tally_in  (chain_in[k]),
        .tally_out (tally[k])
      );
    end
  endgenerate

  kmm_sel #(
    .PATTERN_MAX (PATTERN_MAX),
    .LEN_W       (LEN_W)
  ) u_sel (
    .clk       (clk),
    .rst_n     (rst_n),
    .tally     (tally),
    .a_valid   (a_valid_r),
    .a_start   (a_start_r),
    .a_sel     (a_sel_r),
    .max_mis   (cfg_max_r),
    .b_ready   (b_ready),
    .out_valid (out_valid),
    .out_ready (out_tready),
    .out_res   (out_res)
  );

  assign out_tvalid = out_valid;
  assign out_tdata  = {4'b0000, out_res};

endmodule

`default_nettype wire
